/* sv/priority_task_list_picker_macros.svh */
// Assertion macros for the priority task list picker.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef PRIORITY_TASK_LIST_PICKER_MACROS_SVH
`define PRIORITY_TASK_LIST_PICKER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define PTLP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define PTLP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define PTLP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define PTLP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* sv/ptlp_pkg.sv */
// Shared types, constants and helper functions for the priority task list picker.
// Used by ptlp_ram's instance in the top level and by priority_task_list_picker.
package ptlp_pkg;

  localparam int CAPACITY  = 32;
  localparam int TIME_BITS = 48;

  localparam int POS_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int LIM_W = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [5:0]  SCAN_RESET   = 6'd20;
  localparam logic [31:0] STARVE_RESET = 32'd16000000;

  typedef enum logic [1:0] {
    KIND_ENQUEUE = 2'd0,
    KIND_DEQUEUE = 2'd1,
    KIND_PICK    = 2'd2,
    KIND_REFRESH = 2'd3
  } ptlp_kind_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_IGNORED = 2'd1,
    STAT_FULL    = 2'd2
  } ptlp_status_e;

  typedef enum logic [0:0] {
    CFG_SCAN_LIMIT = 1'b0,
    CFG_STARVE_NS  = 1'b1
  } ptlp_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_FINISH
  } ptlp_state_e;

  typedef struct packed {
    ptlp_kind_e           kind;
    logic [15:0]          task_id;
    logic [TIME_BITS-1:0] vruntime;
    logic [TIME_BITS-1:0] run_start;
    logic [TIME_BITS-1:0] now;
    logic                 throttled;
    logic                 eligible;
  } ptlp_in_t;

  typedef struct packed {
    ptlp_status_e status;
    logic         picked_valid;
    logic [15:0]  picked_task;
    logic         by_starvation;
    logic [5:0]   entry_count;
  } ptlp_out_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [15:0]          task_id;
    logic [TIME_BITS-1:0] vruntime;
    logic [TIME_BITS-1:0] run_start;
  } ptlp_entry_t;

  localparam int ENTRY_W = $bits(ptlp_entry_t);

  // Wrap-aware "a is earlier than b": sign of the modulo difference.
  function automatic logic time_before(logic [TIME_BITS-1:0] a, logic [TIME_BITS-1:0] b);
    logic [TIME_BITS-1:0] diff;
    diff = a - b;
    return diff[TIME_BITS-1];
  endfunction

endpackage

/* sv/ptlp_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Stand-alone; no package dependencies.
module ptlp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* sv/priority_task_list_picker.sv */
// Top level of the priority task list picker: control sequencer around one entry RAM.
// Depends on ptlp_pkg, ptlp_ram and priority_task_list_picker_macros.svh.
//
// Usage. One input channel carries commands (enqueue, dequeue, pick, refresh) with
// valid/stall handshaking; one output channel returns exactly one result per command.
// A transfer happens at a rising edge where valid is high and stall is low.
// The table lives in an entry RAM kept in insertion order by position, so the head of
// the list is RAM address zero. A command scans occupied positions from the head with one RAM
// read per cycle. For a command that scans n entries (n = count, or for a pick the effective
// scan limit capped at the count, zero when the command is rejected up front) the decide and
// finish steps follow its n reads and load the result into the output register. A dequeue of p
// also moves the count - p - 1 entries behind it down by one, one entry per cycle.
// The RAM read port is what sets this rate; one command is in flight at a time.
// The input stalls while a command is in flight, but a finished result sits in the
// output register, so a new command is taken while the receiver still stalls the
// previous result; the sequencer only waits at its final step if that register is full.
// Reset empties the table (count goes to zero) and restores the scan limit (20) and the
// starvation threshold (16000000). The RAM needs no clearing: only positions below the
// count are ever read. Configuration writes are taken whenever the write enable is high
// and are expected only while the block is idle.
module priority_task_list_picker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ptlp_pkg::ptlp_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ptlp_pkg::ptlp_out_t   out_data_o,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [31:0]           cfg_data_i
);

`include "priority_task_list_picker_macros.svh"

  // Running best entry of a pick scan.
  typedef struct packed {
    logic [ptlp_pkg::POS_W-1:0]     pos;
    logic [15:0]                    task_id;
    logic [ptlp_pkg::TIME_BITS-1:0] key;
  } best_t;

  ptlp_pkg::ptlp_state_e state_q, state_d;
  ptlp_pkg::ptlp_in_t    item_q, item_d;
  ptlp_pkg::ptlp_out_t   res_q, res_d;
  ptlp_pkg::ptlp_out_t   out_q, out_d;
  logic                  out_valid_q, out_valid_d;

  logic [ptlp_pkg::CNT_W-1:0] count_q, count_d;
  logic [ptlp_pkg::LIM_W-1:0] idx_q, idx_d;
  logic [ptlp_pkg::LIM_W-1:0] lim_q, lim_d;
  logic                       pend_q, pend_d;
  logic [ptlp_pkg::POS_W-1:0] pend_pos_q, pend_pos_d;
  logic                       found_q, found_d;
  logic [ptlp_pkg::POS_W-1:0] found_pos_q, found_pos_d;
  best_t                      least_q, least_d;
  best_t                      oldest_q, oldest_d;

  logic [5:0]  scan_limit_q;
  logic [31:0] starve_q;

  // Entry RAM ports.
  logic                       ram_we;
  logic [ptlp_pkg::POS_W-1:0] ram_waddr;
  ptlp_pkg::ptlp_entry_t      ram_wentry;
  logic                       ram_re;
  logic [ptlp_pkg::POS_W-1:0] ram_raddr;
  logic [ptlp_pkg::ENTRY_W-1:0] ram_wdata;
  logic [ptlp_pkg::ENTRY_W-1:0] ram_rdata;
  ptlp_pkg::ptlp_entry_t      rd_entry;

  // Scan length helpers.
  logic [ptlp_pkg::LIM_W-1:0] count_ext;
  logic [ptlp_pkg::LIM_W-1:0] eff_limit;
  logic [ptlp_pkg::LIM_W-1:0] pick_lim;
  logic [ptlp_pkg::TIME_BITS-1:0] wait_time;
  logic                       enq_ok;

  assign ram_wdata = ram_wentry;
  assign rd_entry  = ram_rdata;

  ptlp_ram #(
    .WIDTH (ptlp_pkg::ENTRY_W),
    .DEPTH (ptlp_pkg::CAPACITY)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o  = (state_q != ptlp_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A scan limit of zero still looks at the head entry; the scan never passes the count.
  assign count_ext = ptlp_pkg::LIM_W'(count_q);
  assign eff_limit = (scan_limit_q == '0) ? ptlp_pkg::LIM_W'(1)
                                          : ptlp_pkg::LIM_W'(scan_limit_q);
  assign pick_lim  = (eff_limit < count_ext) ? eff_limit : count_ext;

  // Enqueue is only considered for an unthrottled, eligible task.
  assign enq_ok    = !item_q.throttled && item_q.eligible;
  assign wait_time = item_q.now - oldest_q.key;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    pend_d      = pend_q;
    pend_pos_d  = pend_pos_q;
    found_d     = found_q;
    found_pos_d = found_pos_q;
    least_d     = least_q;
    oldest_d    = oldest_q;

    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wentry = rd_entry;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    // The output register empties when its transfer completes.
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ptlp_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          idx_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          unique case (in_data_i.kind)
            ptlp_pkg::KIND_ENQUEUE: begin
              lim_d = (!in_data_i.throttled && in_data_i.eligible) ? count_ext : '0;
            end
            ptlp_pkg::KIND_DEQUEUE,
            ptlp_pkg::KIND_REFRESH: begin
              lim_d = count_ext;
            end
            ptlp_pkg::KIND_PICK: begin
              lim_d = in_data_i.throttled ? '0 : pick_lim;
            end
            default: begin
              lim_d = '0;
            end
          endcase
          state_d = ptlp_pkg::ST_SCAN;
        end
      end

      ptlp_pkg::ST_SCAN,
      ptlp_pkg::ST_SHIFT: begin
        // Issue one read per cycle; the data comes back in the next cycle.
        if (idx_q < lim_q) begin
          ram_re     = 1'b1;
          ram_raddr  = idx_q[ptlp_pkg::POS_W-1:0];
          idx_d      = idx_q + ptlp_pkg::LIM_W'(1);
          pend_d     = 1'b1;
          pend_pos_d = idx_q[ptlp_pkg::POS_W-1:0];
        end else begin
          pend_d = 1'b0;
        end

        if (pend_q) begin
          if (state_q == ptlp_pkg::ST_SCAN) begin
            if (!found_q && rd_entry.task_id == item_q.task_id) begin
              found_d     = 1'b1;
              found_pos_d = pend_pos_q;
            end
            // The head entry seeds both trackers; later entries win only when strictly
            // earlier, so ties keep the earlier position.
            if (pend_pos_q == '0) begin
              least_d  = '{pos: pend_pos_q, task_id: rd_entry.task_id,
                           key: rd_entry.vruntime};
              oldest_d = '{pos: pend_pos_q, task_id: rd_entry.task_id,
                           key: rd_entry.run_start};
            end else begin
              if (ptlp_pkg::time_before(rd_entry.vruntime, least_q.key)) begin
                least_d = '{pos: pend_pos_q, task_id: rd_entry.task_id,
                            key: rd_entry.vruntime};
              end
              if (ptlp_pkg::time_before(rd_entry.run_start, oldest_q.key)) begin
                oldest_d = '{pos: pend_pos_q, task_id: rd_entry.task_id,
                             key: rd_entry.run_start};
              end
            end
          end else begin
            // Close the gap: each entry behind the removed one moves up one position.
            ram_we     = 1'b1;
            ram_waddr  = pend_pos_q - ptlp_pkg::POS_W'(1);
            ram_wentry = rd_entry;
          end
        end

        if (idx_q >= lim_q && !pend_q) begin
          if (state_q == ptlp_pkg::ST_SCAN) begin
            state_d = ptlp_pkg::ST_DECIDE;
          end else begin
            count_d = count_q - ptlp_pkg::CNT_W'(1);
            state_d = ptlp_pkg::ST_FINISH;
          end
        end
      end

      ptlp_pkg::ST_DECIDE: begin
        res_d = '{status: ptlp_pkg::STAT_IGNORED, picked_valid: 1'b0, picked_task: '0,
                  by_starvation: 1'b0, entry_count: '0};
        state_d = ptlp_pkg::ST_FINISH;
        unique case (item_q.kind)
          ptlp_pkg::KIND_ENQUEUE: begin
            if (enq_ok && !found_q) begin
              if (count_q == ptlp_pkg::CNT_W'(ptlp_pkg::CAPACITY)) begin
                res_d.status = ptlp_pkg::STAT_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count_q[ptlp_pkg::POS_W-1:0];
                ram_wentry = '{task_id: item_q.task_id, vruntime: item_q.vruntime,
                               run_start: item_q.run_start};
                count_d      = count_q + ptlp_pkg::CNT_W'(1);
                res_d.status = ptlp_pkg::STAT_DONE;
              end
            end
          end
          ptlp_pkg::KIND_REFRESH: begin
            if (found_q) begin
              ram_we     = 1'b1;
              ram_waddr  = found_pos_q;
              ram_wentry = '{task_id: item_q.task_id, vruntime: item_q.vruntime,
                             run_start: item_q.run_start};
              res_d.status = ptlp_pkg::STAT_DONE;
            end
          end
          ptlp_pkg::KIND_DEQUEUE: begin
            if (found_q) begin
              res_d.status = ptlp_pkg::STAT_DONE;
              if (ptlp_pkg::LIM_W'(found_pos_q) + ptlp_pkg::LIM_W'(1) < count_ext) begin
                idx_d   = ptlp_pkg::LIM_W'(found_pos_q) + ptlp_pkg::LIM_W'(1);
                lim_d   = count_ext;
                pend_d  = 1'b0;
                state_d = ptlp_pkg::ST_SHIFT;
              end else begin
                count_d = count_q - ptlp_pkg::CNT_W'(1);
              end
            end
          end
          ptlp_pkg::KIND_PICK: begin
            if (!item_q.throttled && count_q != '0) begin
              res_d.status       = ptlp_pkg::STAT_DONE;
              res_d.picked_valid = 1'b1;
              res_d.picked_task  = least_q.task_id;
              // The oldest entry overrides when it is a different entry and has waited past the threshold.
              if (oldest_q.pos != least_q.pos &&
                  wait_time > ptlp_pkg::TIME_BITS'(starve_q)) begin
                res_d.picked_task   = oldest_q.task_id;
                res_d.by_starvation = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end

      ptlp_pkg::ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d             = res_q;
          out_d.entry_count = 6'(count_q);
          out_valid_d       = 1'b1;
          state_d           = ptlp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ptlp_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ptlp_pkg::ST_IDLE;
      out_valid_q  <= 1'b0;
      count_q      <= '0;
      idx_q        <= '0;
      lim_q        <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      scan_limit_q <= ptlp_pkg::SCAN_RESET;
      starve_q     <= ptlp_pkg::STARVE_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      lim_q       <= lim_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == ptlp_pkg::CFG_SCAN_LIMIT) begin
          scan_limit_q <= cfg_data_i[5:0];
        end else begin
          starve_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q      <= item_d;
    res_q       <= res_d;
    out_q       <= out_d;
    pend_pos_q  <= pend_pos_d;
    found_pos_q <= found_pos_d;
    least_q     <= least_d;
    oldest_q    <= oldest_d;
  end

  `PTLP_ASSERT_IMP(a_count_range, clk_i, rst_ni, 1'b1, count_q <= ptlp_pkg::CNT_W'(ptlp_pkg::CAPACITY), "entry count exceeds capacity")
  `PTLP_ASSERT_IMP(a_write_in_table, clk_i, rst_ni, ram_we, ptlp_pkg::LIM_W'(ram_waddr) <= count_ext, "entry RAM written beyond the occupied table")
  `PTLP_ASSERT_NXT(a_count_idle, clk_i, rst_ni, state_q == ptlp_pkg::ST_IDLE, $stable(count_q), "entry count changed outside a command")
  `PTLP_ASSERT_IMP(a_read_in_scan, clk_i, rst_ni, pend_q, state_q == ptlp_pkg::ST_SCAN || state_q == ptlp_pkg::ST_SHIFT, "RAM read data pending outside a scan")
  `PTLP_ASSERT_IMP(a_pick_done, clk_i, rst_ni, out_valid_q && out_q.picked_valid, out_q.status == ptlp_pkg::STAT_DONE, "picked task reported without done status")

endmodule

/* dv/ptlp_checker.sv */
// Result checker for the priority task list picker: keeps its own copy of the task
// table, predicts one result per accepted command and compares every accepted result.
// Depends on ptlp_pkg for the channel payload types, codes and sizes.
module ptlp_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  ptlp_pkg::ptlp_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  ptlp_pkg::ptlp_out_t out_data_i,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  output int                  fail_count,
  output int                  outstanding,
  output int                  results_seen,
  output int                  picks_done,
  output int                  starved_picks,
  output int                  full_rejects
);

  logic [15:0]                    tbl_task  [ptlp_pkg::CAPACITY];
  logic [ptlp_pkg::TIME_BITS-1:0] tbl_vr    [ptlp_pkg::CAPACITY];
  logic [ptlp_pkg::TIME_BITS-1:0] tbl_start [ptlp_pkg::CAPACITY];
  logic [ptlp_pkg::POS_W-1:0]     tbl_order [ptlp_pkg::CAPACITY];
  int unsigned                    tbl_count;
  logic [5:0]                     cur_scan;
  logic [31:0]                    cur_starve;

  ptlp_pkg::ptlp_out_t expected_results[$];

  function automatic logic is_earlier(logic [ptlp_pkg::TIME_BITS-1:0] a,
                                      logic [ptlp_pkg::TIME_BITS-1:0] b);
    logic [ptlp_pkg::TIME_BITS-1:0] delta;
    delta = a - b;
    return delta[ptlp_pkg::TIME_BITS-1];
  endfunction

  // Position of a task in insertion order, or -1 when it is not in the table.
  function automatic int locate(logic [15:0] id);
    for (int i = 0; i < int'(tbl_count); i++) begin
      if (tbl_task[tbl_order[i]] == id) return i;
    end
    return -1;
  endfunction

  function automatic ptlp_pkg::ptlp_out_t apply_command(input ptlp_pkg::ptlp_in_t cmd);
    ptlp_pkg::ptlp_out_t            res;
    int                             pos;
    int                             seen;
    logic [ptlp_pkg::POS_W-1:0]     slot;
    logic [ptlp_pkg::POS_W-1:0]     least;
    logic [ptlp_pkg::POS_W-1:0]     oldest;
    logic [ptlp_pkg::TIME_BITS-1:0] waited;
    res = '0;
    res.status = ptlp_pkg::STAT_IGNORED;
    case (cmd.kind)
      ptlp_pkg::KIND_ENQUEUE: begin
        if (!cmd.throttled && cmd.eligible && locate(cmd.task_id) < 0) begin
          if (tbl_count >= ptlp_pkg::CAPACITY) begin
            res.status = ptlp_pkg::STAT_FULL;
            full_rejects++;
          end else begin
            slot = tbl_order[tbl_count];
            tbl_task[slot]  = cmd.task_id;
            tbl_vr[slot]    = cmd.vruntime;
            tbl_start[slot] = cmd.run_start;
            tbl_count++;
            res.status = ptlp_pkg::STAT_DONE;
          end
        end
      end
      ptlp_pkg::KIND_DEQUEUE: begin
        pos = locate(cmd.task_id);
        if (pos >= 0) begin
          // The freed slot goes to the first free position, behind the live entries.
          slot = tbl_order[pos];
          for (int i = pos; i + 1 < int'(tbl_count); i++) tbl_order[i] = tbl_order[i + 1];
          tbl_order[tbl_count - 1] = slot;
          tbl_count--;
          res.status = ptlp_pkg::STAT_DONE;
        end
      end
      ptlp_pkg::KIND_REFRESH: begin
        pos = locate(cmd.task_id);
        if (pos >= 0) begin
          slot = tbl_order[pos];
          tbl_vr[slot]    = cmd.vruntime;
          tbl_start[slot] = cmd.run_start;
          res.status = ptlp_pkg::STAT_DONE;
        end
      end
      default: begin
        if (!cmd.throttled && tbl_count > 0) begin
          least  = tbl_order[0];
          oldest = least;
          seen   = 0;
          // A scan limit of zero still looks at the head entry.
          for (int i = 0; i < int'(tbl_count); i++) begin
            slot = tbl_order[i];
            if (is_earlier(tbl_vr[slot], tbl_vr[least])) least = slot;
            if (is_earlier(tbl_start[slot], tbl_start[oldest])) oldest = slot;
            seen++;
            if (seen >= int'(cur_scan)) break;
          end
          res.status       = ptlp_pkg::STAT_DONE;
          res.picked_valid = 1'b1;
          res.picked_task  = tbl_task[least];
          waited = cmd.now - tbl_start[oldest];
          if (oldest != least &&
              waited > {{(ptlp_pkg::TIME_BITS-32){1'b0}}, cur_starve}) begin
            res.picked_task   = tbl_task[oldest];
            res.by_starvation = 1'b1;
            starved_picks++;
          end
          picks_done++;
        end
      end
    endcase
    res.entry_count = 6'(tbl_count);
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got)
      report_mismatch($sformatf("result %0d field %s: expected 0x%0h, got 0x%0h",
                                results_seen, name, want, got));
  endtask

  task automatic check_result(ptlp_pkg::ptlp_out_t got);
    ptlp_pkg::ptlp_out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result 0x%0h arrived with nothing expected", got));
    end else begin
      want = expected_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("picked_valid", want.picked_valid, got.picked_valid);
      check_field("picked_task", want.picked_task, got.picked_task);
      check_field("by_starvation", want.by_starvation, got.by_starvation);
      check_field("entry_count", want.entry_count, got.entry_count);
    end
    results_seen++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptlp_pkg::CAPACITY; i++) tbl_order[i] = ptlp_pkg::POS_W'(i);
      tbl_count  = 0;
      cur_scan   = ptlp_pkg::SCAN_RESET;
      cur_starve = ptlp_pkg::STARVE_RESET;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) check_result(out_data_i);
      if (in_valid_i && !in_stall_i) expected_results.push_back(apply_command(in_data_i));
      if (cfg_we_i) begin
        case (ptlp_pkg::ptlp_cfg_e'(cfg_idx_i))
          ptlp_pkg::CFG_SCAN_LIMIT: cur_scan = cfg_data_i[5:0];
          default:                  cur_starve = cfg_data_i;
        endcase
      end
    end
    outstanding = expected_results.size();
  end

endmodule

/* dv/tb_top.sv */
// Top of the priority task list picker testbench: clock, reset, command stimulus and
// result back-pressure, configuration phases and the final verdict.
// Depends on ptlp_pkg, priority_task_list_picker and ptlp_checker.
module tb_top;

  // All block inputs start at known values; after time zero they only change on the
  // falling clock edge, so the block and the checker see stable values at the rising edge.
  logic                clk;
  logic                rst_n      = 1'b0;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  ptlp_pkg::ptlp_in_t  in_data    = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  ptlp_pkg::ptlp_out_t out_data;
  logic                cfg_we     = 1'b0;
  logic [0:0]          cfg_idx    = ptlp_pkg::CFG_SCAN_LIMIT;
  logic [31:0]         cfg_data   = '0;

  int fail_count;
  int outstanding;
  int results_seen;
  int picks_done;
  int starved_picks;
  int full_rejects;

  // When set, both sides run back to back with no idle cycles.
  logic quiet = 1'b0;

  // A small pool of handles, so that dequeues and refreshes mostly hit live tasks and the
  // table fills up; a tenth of the random commands use a fully random handle instead.
  logic [15:0] id_pool [40];

  logic [ptlp_pkg::TIME_BITS-1:0] sched_clock;
  logic [ptlp_pkg::TIME_BITS-1:0] vr_base;

  priority_task_list_picker dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  ptlp_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_data_i     (in_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_data_i    (out_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .picks_done    (picks_done),
    .starved_picks (starved_picks),
    .full_rejects  (full_rejects)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run. The slowest legal run is about 500 commands, each with a full
  // dequeue shift plus the longest gaps and stalls, plus one long hold on the output;
  // this leaves a wide margin above that.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [ptlp_pkg::TIME_BITS-1:0] rand_time();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[ptlp_pkg::TIME_BITS-1:0];
  endfunction

  function automatic ptlp_pkg::ptlp_in_t compose_command(
      ptlp_pkg::ptlp_kind_e k, logic [15:0] id,
      logic [ptlp_pkg::TIME_BITS-1:0] vr,
      logic [ptlp_pkg::TIME_BITS-1:0] st,
      logic [ptlp_pkg::TIME_BITS-1:0] nw,
      logic thr, logic elig);
    ptlp_pkg::ptlp_in_t cmd;
    cmd.kind      = k;
    cmd.task_id   = id;
    cmd.vruntime  = vr;
    cmd.run_start = st;
    cmd.now       = nw;
    cmd.throttled = thr;
    cmd.eligible  = elig;
    return cmd;
  endfunction

  // Offers one command after a random gap and returns once its transfer has happened.
  // Valid gets exactly one assignment per falling edge, so a back-to-back command keeps
  // valid high without a glitch.
  task automatic send_cmd(ptlp_pkg::ptlp_in_t cmd);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_data  <= cmd;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Configuration is only written while the block is idle: the sender stops, every
  // expected result has come back, and a few more cycles pass before the write.
  task automatic reconfigure(logic [5:0] scan, logic [31:0] starve);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= ptlp_pkg::CFG_SCAN_LIMIT;
    cfg_data <= {26'd0, scan};
    @(negedge clk);
    cfg_idx  <= ptlp_pkg::CFG_STARVE_NS;
    cfg_data <= starve;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Short directed sequence under the reset configuration (scan 20, threshold 16000000).
  // It covers a pick on an empty table, the throttled, ineligible and duplicate enqueue
  // rejections in their order of precedence, absent dequeue and refresh, throttled pick,
  // extreme times that wrap, ties on both runtime and start, a wait just past the threshold,
  // and dequeues from the middle and the head that must keep the order of the rest.
  task automatic run_directed();
    logic [ptlp_pkg::TIME_BITS-1:0] all_ones;
    all_ones = '1;
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'h0000, '0, '0, '0, 1'b1, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'h0000, '0, '0, '0, 1'b0, 1'b0));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'h0000, all_ones, '0, '0,
                             1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'hFFFF, '0, all_ones, '0,
                             1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'h0000, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'h5A5A, 48'h8000_0000_0000,
                             48'h7FFF_FFFF_FFFF, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, '0, 1'b1, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, all_ones,
                             1'b0, 1'b0));
    send_cmd(compose_command(ptlp_pkg::KIND_REFRESH, 16'h5A5A, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_REFRESH, 16'h1234, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_ENQUEUE, 16'h1111, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, 48'd16000001,
                             1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, 48'd16000000,
                             1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_DEQUEUE, 16'h4321, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_DEQUEUE, 16'hFFFF, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, 48'h0000_1000_0000,
                             1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_DEQUEUE, 16'h0000, '0, '0, '0, 1'b0, 1'b1));
    send_cmd(compose_command(ptlp_pkg::KIND_REFRESH, 16'h1111, 48'h0000_0000_0001,
                             48'hFFFF_FFFF_FFF0, '0, 1'b1, 1'b0));
    send_cmd(compose_command(ptlp_pkg::KIND_DEQUEUE, 16'h1111, '0, '0, '0, 1'b1, 1'b0));
    send_cmd(compose_command(ptlp_pkg::KIND_PICK,    16'h0000, '0, '0, 48'h0000_2000_0000,
                             1'b0, 1'b1));
  endtask

  // Random commands with the given mix in percent (enqueue, dequeue, pick; refresh takes
  // the rest). Most times are kept near a moving scheduler clock so that waits land on
  // both sides of the threshold; one command in ten uses fully random times instead,
  // which also exercises wrap-around in the signed comparisons.
  task automatic run_random(int n, int enq_pct, int deq_pct, int pick_pct);
    int                             roll;
    ptlp_pkg::ptlp_kind_e           k;
    logic [15:0]                    id;
    logic [ptlp_pkg::TIME_BITS-1:0] vr;
    logic [ptlp_pkg::TIME_BITS-1:0] st;
    logic [ptlp_pkg::TIME_BITS-1:0] nw;
    logic [ptlp_pkg::TIME_BITS-1:0] wait_span;
    for (int c = 0; c < n; c++) begin
      roll = $urandom_range(0, 99);
      if (roll < enq_pct) k = ptlp_pkg::KIND_ENQUEUE;
      else if (roll < enq_pct + deq_pct) k = ptlp_pkg::KIND_DEQUEUE;
      else if (roll < enq_pct + deq_pct + pick_pct) k = ptlp_pkg::KIND_PICK;
      else k = ptlp_pkg::KIND_REFRESH;
      id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : id_pool[$urandom_range(0, 39)];
      sched_clock = sched_clock + ptlp_pkg::TIME_BITS'($urandom_range(0, 1 << 20));
      vr_base     = vr_base + ptlp_pkg::TIME_BITS'($urandom_range(0, 1 << 16));
      if ($urandom_range(0, 9) == 0) begin
        vr = rand_time();
        st = rand_time();
        nw = rand_time();
      end else begin
        // A quarter of the waits reach up to 2^34, past even the largest threshold.
        if ($urandom_range(0, 3) == 0)
          wait_span = {14'd0, 2'($urandom_range(0, 3)), $urandom};
        else
          wait_span = ptlp_pkg::TIME_BITS'($urandom_range(0, 1 << 25));
        vr = vr_base + ptlp_pkg::TIME_BITS'($urandom_range(0, 1 << 24));
        st = sched_clock - ptlp_pkg::TIME_BITS'($urandom_range(0, 1 << 26));
        nw = sched_clock + wait_span;
      end
      send_cmd(compose_command(k, id, vr, st, nw, $urandom_range(0, 7) == 0,
                               $urandom_range(0, 7) != 0));
    end
  endtask

  // Result side. Before each result it holds stall for a random number of cycles, then
  // releases it and waits for the transfer. Once, early in the first random phase, it
  // holds for a long stretch while the sender keeps offering commands, so the output
  // register fills and the block has to stall its input.
  initial begin : result_sink
    int hold;
    int taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 6);
      if (taken == 60) hold = 80;
      repeat (hold) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < 40; i++) id_pool[i] = 16'($urandom);
    sched_clock = rand_time();
    vr_base     = rand_time();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: directed checks, then an enqueue-heavy mix that fills the
    // table so that full-table rejections show up.
    run_directed();
    run_random(100, 55, 10, 25);

    // Widest scan with no threshold: any distinct oldest entry with a nonzero wait wins. Back to back.
    reconfigure(6'd32, 32'd0);
    quiet = 1'b1;
    run_random(70, 35, 15, 35);
    quiet = 1'b0;

    // Single-entry scan and the largest threshold.
    reconfigure(6'd1, 32'hFFFF_FFFF);
    run_random(70, 30, 20, 35);

    // Scan limit of zero, which still examines the head, and a tiny threshold.
    reconfigure(6'd0, 32'd1000);
    run_random(60, 30, 20, 35);

    // Scan limit beyond the table size and a random threshold.
    reconfigure(6'd63, $urandom);
    run_random(70, 30, 20, 35);

    // Random in-range scan limit, back to the default threshold, draining the table.
    reconfigure(6'($urandom_range(1, 32)), ptlp_pkg::STARVE_RESET);
    run_random(100, 15, 45, 30);

    @(negedge clk);
    in_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (80) @(posedge clk);

    $display("Run covered %0d results over six scan/threshold settings: %0d picks,",
             results_seen, picks_done);
    $display("%0d of them won by starvation, and %0d full-table rejections.",
             starved_picks, full_rejects);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ptlp_pkg.sv
sv/ptlp_ram.sv
sv/priority_task_list_picker.sv
dv/ptlp_checker.sv
dv/tb_top.sv
